FILE: rtl/udphc_pkg.sv
// Shared types and constants for the UDP header decode and checksum check block.
// Depends on nothing; imported by udp_header_check_decode.
package udphc_pkg;

    // Fixed UDP header size in bytes.
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    // IP protocol number of UDP, summed into the pseudo-header.
    localparam logic [15:0] UDP_PROTO   = 16'd17;
    // Ones'-complement sum of a datagram whose checksum verifies.
    localparam logic [15:0] SUM_GOOD    = 16'hFFFF;
    // Saturation value of the byte counter.
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // Verdict codes; the first check that fails in this order decides.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,  // all checks passed
        ST_SHORT  = 3'd1,  // fewer than eight bytes received
        ST_TRUNC  = 3'd2,  // fewer bytes received than the length field
        ST_BADLEN = 3'd4,  // length field below eight
        ST_BADSUM = 3'd3   // checksum present and wrong
    } udphc_status_t;

    // One verdict as it waits in the output registers.
    typedef struct packed {
        logic          accepted;
        udphc_status_t status;
        logic [15:0]   src_port;
        logic [15:0]   dst_port;
        logic [15:0]   payload_length;
    } udphc_result_t;

endpackage

FILE: rtl/udp_header_check_decode.sv
// UDP header decode and checksum verify, one datagram byte per transaction.
// Depends on udphc_pkg (status codes, result struct, header constants).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | in_valid/in_stall  | data_byte, last_byte, src_ip, dst_ip
//  output  | out       | out_valid/out_stall| accepted, status, src_port, dst_port,
//          |           |                    | payload_length
//
// One input transaction is taken every cycle while in_stall is low; a byte's work
// is a single multi-operand ones'-complement add with two folds, done between the
// state registers and the result registers. A verdict is registered in the result
// register, or in the skid register if the result is held; this two-entry output
// lets input continue while a verdict waits; in_stall rises only once the skid
// register is occupied. Reset clears all datagram state and both output slots.
module udp_header_check_decode
    import udphc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [2:0]  status,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [15:0] payload_length
);

    // Datagram state.
    logic [15:0]   count_reg;
    logic [15:0]   sum_reg;
    logic [7:0]    hold_reg;
    logic [15:0]   sport_reg;
    logic [15:0]   dport_reg;
    logic [15:0]   len_reg;
    logic          csum_present_reg;

    logic [15:0]   count_next;
    logic [15:0]   sum_next;
    logic [7:0]    hold_next;
    logic [15:0]   sport_next;
    logic [15:0]   dport_next;
    logic [15:0]   len_next;
    logic          csum_present_next;

    // Output slots.
    logic          out_valid_reg;
    udphc_result_t out_data_reg;
    logic          skid_valid_reg;
    udphc_result_t skid_data_reg;

    logic          in_fire;
    logic          push;
    logic          pop;
    logic          word_en;
    logic [16:0]   n_bytes;
    logic [15:0]   t0, t1, t2, t3, t4;
    logic [18:0]   total;
    logic [16:0]   fold1;
    logic          pad_en;
    udphc_status_t status_new;
    udphc_result_t res_new;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid & ~in_stall;
    assign push     = in_fire & last_byte;
    assign pop      = out_valid_reg & ~out_stall;

    // Per-byte decode and sum update.
    always_comb
    begin
        sport_next        = sport_reg;
        dport_next        = dport_reg;
        len_next          = len_reg;
        csum_present_next = csum_present_reg;

        unique case (count_reg)
            16'd0:   sport_next = {data_byte, 8'h00};
            16'd1:   sport_next = {sport_reg[15:8], data_byte};
            16'd2:   dport_next = {data_byte, 8'h00};
            16'd3:   dport_next = {dport_reg[15:8], data_byte};
            16'd4:   len_next   = {data_byte, 8'h00};
            16'd5:   len_next   = {len_reg[15:8], data_byte};
            16'd6,
            16'd7:   csum_present_next = csum_present_reg | (data_byte != 8'h00);
            default: ;
        endcase

        // Bytes past the length field are padding and stay out of the sum.
        word_en   = (count_reg < 16'd6) || (count_reg < len_reg);
        hold_next = (word_en && !count_reg[0]) ? data_byte : hold_reg;
        n_bytes   = {1'b0, count_reg} + 17'd1;

        // An odd trailing byte is summed with a zero low byte once lengths pass.
        pad_en = last_byte && len_next[0]
               && (n_bytes >= {1'b0, UDP_HDR_LEN})
               && (n_bytes >= {1'b0, len_next})
               && (len_next >= UDP_HDR_LEN);

        if (count_reg == 16'd0)
        begin
            // Pseudo-header: addresses and protocol.
            t0 = src_ip[31:16];
            t1 = src_ip[15:0];
            t2 = dst_ip[31:16];
            t3 = dst_ip[15:0];
            t4 = UDP_PROTO;
        end
        else
        begin
            t0 = (word_en && count_reg[0]) ? {hold_reg, data_byte} : 16'h0000;
            t1 = (count_reg == 16'd5) ? len_next : 16'h0000;
            t2 = pad_en ? {hold_next, 8'h00} : 16'h0000;
            t3 = 16'h0000;
            t4 = 16'h0000;
        end

        // End-around carry: two folds bring any total back into 16 bits.
        total = {3'b000, sum_reg} + {3'b000, t0} + {3'b000, t1} + {3'b000, t2}
              + {3'b000, t3} + {3'b000, t4};
        fold1    = {1'b0, total[15:0]} + {14'b0, total[18:16]};
        sum_next = fold1[15:0] + {15'b0, fold1[16]};

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

        priority if (n_bytes < {1'b0, UDP_HDR_LEN})
            status_new = ST_SHORT;
        else if (n_bytes < {1'b0, len_next})
            status_new = ST_TRUNC;
        else if (len_next < UDP_HDR_LEN)
            status_new = ST_BADLEN;
        else if (csum_present_next && (sum_next != SUM_GOOD))
            status_new = ST_BADSUM;
        else
            status_new = ST_OK;

        res_new.accepted       = (status_new == ST_OK);
        res_new.status         = status_new;
        res_new.src_port       = (status_new == ST_OK) ? sport_next : 16'h0000;
        res_new.dst_port       = (status_new == ST_OK) ? dport_next : 16'h0000;
        res_new.payload_length = (status_new == ST_OK) ? (len_next - UDP_HDR_LEN)
                                                       : 16'h0000;
    end

    // Advance datagram state; drop it all after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sum_reg          <= '0;
            hold_reg         <= '0;
            sport_reg        <= '0;
            dport_reg        <= '0;
            len_reg          <= '0;
            csum_present_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                count_reg        <= '0;
                sum_reg          <= '0;
                hold_reg         <= '0;
                sport_reg        <= '0;
                dport_reg        <= '0;
                len_reg          <= '0;
                csum_present_reg <= 1'b0;
            end
            else
            begin
                count_reg        <= count_next;
                sum_reg          <= sum_next;
                hold_reg         <= hold_next;
                sport_reg        <= sport_next;
                dport_reg        <= dport_next;
                len_reg          <= len_next;
                csum_present_reg <= csum_present_next;
            end
        end
    end

    // Output slot control: the skid register catches a verdict that arrives
    // while the result register is held by a stalled consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= res_new;
            else
                out_data_reg <= res_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_data_reg.accepted;
    assign status         = 3'(out_data_reg.status);
    assign src_port       = out_data_reg.src_port;
    assign dst_port       = out_data_reg.dst_port;
    assign payload_length = out_data_reg.payload_length;

endmodule

FILE: verif/tb.sv
// Testbench for udp_header_check_decode: drives UDP datagrams byte by byte and
// checks every verdict against an in-bench predictor of the header and checksum checks.
// Depends on udphc_pkg and udp_header_check_decode from the rtl folder.
module tb;
    import udphc_pkg::*;

    // One input transaction: a datagram byte plus the address pair offered with it.
    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] sip;
        logic [31:0] dip;
        bit          hurry;  // send with no gap
    } udp_byte_t;

    // How the checksum field of a generated datagram is filled.
    typedef enum int {CK_ZERO, CK_GOOD, CK_FLIP, CK_RAND} cks_mode_t;

    localparam int RAND_BYTES = 1075;
    localparam int HOLD_AT    = 30;   // verdict count that starts the long receiver hold-off
    localparam int HOLD_LEN   = 400;  // length of that hold-off in cycles

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte      = '0;
    logic        last_byte      = 1'b0;
    logic [31:0] src_ip         = '0;
    logic [31:0] dst_ip         = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        accepted;
    logic [2:0]  status;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;

    udp_byte_t      pending_q[$];   // bytes not yet offered to the block
    udphc_result_t  verdict_q[$];   // verdicts predicted and not yet seen
    udp_byte_t      next_byte;

    int gap_left      = 0;
    int bytes_taken   = 0;
    int stall_left    = 0;
    int verdicts_seen = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int mismatches    = 0;

    // Predictor state for the datagram in flight.
    logic [15:0] dg_count = '0;
    logic [16:0] dg_sum   = '0;
    logic [7:0]  dg_hi    = '0;
    logic [15:0] dg_sport = '0;
    logic [15:0] dg_dport = '0;
    logic [15:0] dg_len   = '0;
    logic        dg_cks   = 1'b0;

    udp_header_check_decode u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .src_ip         (src_ip),
        .dst_ip         (dst_ip),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .status         (status),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .payload_length (payload_length)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Add a 16-bit word into a ones'-complement sum, folding the carry back in.
    function automatic logic [16:0] ones_add16(input logic [16:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = acc + {1'b0, w};
        return {1'b0, s[15:0]} + {16'd0, s[16]};
    endfunction

    // Mostly short gaps, a few long ones; none at all in a quiet stretch.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_dgram;
        dg_count = '0;
        dg_sum   = '0;
        dg_hi    = '0;
        dg_sport = '0;
        dg_dport = '0;
        dg_len   = '0;
        dg_cks   = 1'b0;
    endtask

    // Advance the predictor by one accepted byte; on a last byte, queue the verdict.
    task automatic predict_verdict(input logic [7:0] b, input logic last,
                                   input logic [31:0] sip, input logic [31:0] dip);
        logic [15:0]   idx;
        logic [16:0]   seen;
        udphc_status_t st;
        udphc_result_t v;
        idx = dg_count;
        // Fold the pseudo-header in on the first byte; later addresses are ignored.
        if (idx == 16'd0)
        begin
            dg_sum = ones_add16(dg_sum, sip[31:16]);
            dg_sum = ones_add16(dg_sum, sip[15:0]);
            dg_sum = ones_add16(dg_sum, dip[31:16]);
            dg_sum = ones_add16(dg_sum, dip[15:0]);
            dg_sum = ones_add16(dg_sum, UDP_PROTO);
        end
        case (idx)
            16'd0: dg_sport = {b, 8'h00};
            16'd1: dg_sport[7:0] = b;
            16'd2: dg_dport = {b, 8'h00};
            16'd3: dg_dport[7:0] = b;
            16'd4: dg_len = {b, 8'h00};
            16'd5:
            begin
                dg_len[7:0] = b;
                dg_sum = ones_add16(dg_sum, dg_len);
            end
            16'd6, 16'd7:
            begin
                if (b != 8'h00)
                    dg_cks = 1'b1;
            end
            default: ;
        endcase
        // Sum the first length-field bytes only; padding past it is skipped.
        if (idx < 16'd6 || idx < dg_len)
        begin
            if (!idx[0])
                dg_hi = b;
            else
                dg_sum = ones_add16(dg_sum, {dg_hi, b});
        end
        if (dg_count != COUNT_MAX)
            dg_count = dg_count + 16'd1;
        if (last)
        begin
            seen = {1'b0, idx} + 17'd1;
            if (seen < {1'b0, UDP_HDR_LEN})
                st = ST_SHORT;
            else if (seen < {1'b0, dg_len})
                st = ST_TRUNC;
            else if (dg_len < UDP_HDR_LEN)
                st = ST_BADLEN;
            else
            begin
                if (dg_len[0])
                    dg_sum = ones_add16(dg_sum, {dg_hi, 8'h00});
                st = (dg_cks && dg_sum != {1'b0, SUM_GOOD}) ? ST_BADSUM : ST_OK;
            end
            v.accepted       = (st == ST_OK);
            v.status         = st;
            v.src_port       = (st == ST_OK) ? dg_sport : 16'd0;
            v.dst_port       = (st == ST_OK) ? dg_dport : 16'd0;
            v.payload_length = (st == ST_OK) ? dg_len - UDP_HDR_LEN : 16'd0;
            verdict_q.push_back(v);
            clear_dgram();
        end
    endtask

    // Build one datagram and queue its bytes. The array holds at least the header and
    // plen payload bytes; only the first total bytes are sent. fill < 0 means random data.
    task automatic queue_dgram(input logic [31:0] sip, input logic [31:0] dip,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [15:0] lenf, input int plen, input int total,
                               input cks_mode_t cmode, input int fill, input bit hurry);
        logic [7:0]  dg[$];
        logic [16:0] s;
        logic [15:0] ck;
        logic [7:0]  lo;
        int          nb;
        udp_byte_t   it;
        nb = (total > 8 + plen) ? total : 8 + plen;
        dg = {sport[15:8], sport[7:0], dport[15:8], dport[7:0], lenf[15:8], lenf[7:0],
              8'h00, 8'h00};
        for (int j = 8; j < nb; j++)
            dg.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        // Compute the checksum that makes the whole sum come out all ones.
        s = '0;
        s = ones_add16(s, sip[31:16]);
        s = ones_add16(s, sip[15:0]);
        s = ones_add16(s, dip[31:16]);
        s = ones_add16(s, dip[15:0]);
        s = ones_add16(s, UDP_PROTO);
        s = ones_add16(s, lenf);
        for (int j = 0; j < nb && j < int'(lenf); j += 2)
        begin
            lo = (j + 1 < nb && j + 1 < int'(lenf)) ? dg[j + 1] : 8'h00;
            s = ones_add16(s, {dg[j], lo});
        end
        ck = ~s[15:0];
        if (ck == 16'h0000)
            ck = 16'hFFFF;
        case (cmode)
            CK_ZERO: ck = 16'h0000;
            CK_FLIP: ck = ck ^ (16'h0001 << $urandom_range(0, 15));
            CK_RAND: ck = 16'($urandom);
            default: ;
        endcase
        dg[6] = ck[15:8];
        dg[7] = ck[7:0];
        for (int j = 0; j < total; j++)
        begin
            it.data  = dg[j];
            it.last  = (j == total - 1);
            // Vary the addresses after the first byte; the block must ignore them.
            it.sip   = (j == 0) ? sip : $urandom;
            it.dip   = (j == 0) ? dip : $urandom;
            it.hurry = hurry;
            pending_q.push_back(it);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: hold the payload while stalled, advance on each accepted transaction,
    // and insert random gaps between bytes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
            src_ip    <= '0;
            dst_ip    <= '0;
            gap_left  <= 0;
            clear_dgram();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_verdict(data_byte, last_byte, src_ip, dst_ip);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0 || pending_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    next_byte = pending_q.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= next_byte.data;
                    last_byte <= next_byte.last;
                    src_ip    <= next_byte.sip;
                    dst_ip    <= next_byte.dip;
                    // Drop gaps for hurried datagrams and for one stretch in five.
                    gap_left  <= pick_gap(next_byte.hurry || ((bytes_taken / 150) % 5 == 0));
                end
            end
        end
    end

    // Monitor: compare each accepted verdict with the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            stall_left    <= 0;
            verdicts_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                verdicts_seen <= verdicts_seen + 1;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, got status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    udphc_result_t want;
                    want = verdict_q.pop_front();
                    check_field("accepted", 16'(want.accepted), 16'(accepted));
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("src_port", want.src_port, src_port);
                    check_field("dst_port", want.dst_port, dst_port);
                    check_field("payload_length", want.payload_length, payload_length);
                end
            end
            if (stall_left != 0)
                stall_left <= stall_left - 1;
            else if ($urandom_range(0, 2) == 0)
                stall_left <= pick_gap((verdicts_seen % 25) < 5);
            out_stall <= (hold_left != 0) || (stall_left != 0);
        end
    end

    // Hold off the receiver once for a long stretch so the output fills and the
    // block has to stall its input while the driver keeps offering bytes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && verdicts_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int        base;
        int        kind;
        int        plen;
        int        total;
        int        lenf;
        cks_mode_t cmode;

        // Directed: minimal all-zero datagram, then all-ones header with odd length.
        queue_dgram(32'h0, 32'h0, 16'h0000, 16'h0000, 16'd8, 0, 8, CK_GOOD, 0, 1'b0);
        queue_dgram('1, '1, 16'hFFFF, 16'hFFFF, 16'd13, 5, 13, CK_GOOD, 255, 1'b0);
        // Zero checksum field skips the check, whatever the data.
        queue_dgram($urandom, $urandom, 16'd53, 16'd1024, 16'd12, 4, 12, CK_ZERO, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'd7, 16'd9, 16'd17, 9, 17, CK_GOOD, -1, 1'b0);
        // Bad checksum and a random checksum field.
        queue_dgram($urandom, $urandom, 16'h1234, 16'h5678, 16'd14, 6, 14, CK_FLIP, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'hABCD, 16'h00FF, 16'd10, 2, 10, CK_RAND, -1, 1'b0);
        // Too short: one byte, then seven.
        queue_dgram($urandom, $urandom, 16'h0101, 16'h0202, 16'd8, 0, 1, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'h0303, 16'h0404, 16'd8, 0, 7, CK_GOOD, -1, 1'b0);
        // Truncated, including the largest length field.
        queue_dgram($urandom, $urandom, 16'h1111, 16'h2222, 16'd20, 12, 12, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'h3333, 16'h4444, 16'hFFFF, 12, 20, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'h5555, 16'h6666, 16'd9, 0, 8, CK_GOOD, -1, 1'b0);
        // Length field below eight; it wins over a bad checksum.
        queue_dgram($urandom, $urandom, 16'h7777, 16'h8888, 16'd0, 0, 8, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'h9999, 16'hAAAA, 16'd7, 2, 10, CK_FLIP, -1, 1'b0);
        // Trailing padding past the length field is not summed.
        queue_dgram($urandom, $urandom, 16'hBBBB, 16'hCCCC, 16'd11, 3, 16, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'hDDDD, 16'hEEEE, 16'd8, 0, 11, CK_GOOD, -1, 1'b0);
        queue_dgram($urandom, $urandom, 16'd9, 16'd9, 16'd9, 1, 9, CK_GOOD, -1, 1'b0);

        // Random: mostly well-formed datagrams with random content, the rest broken.
        base = pending_q.size();
        while (pending_q.size() - base < RAND_BYTES)
        begin
            kind  = $urandom_range(0, 99);
            cmode = CK_GOOD;
            if ($urandom_range(0, 19) == 0)
                plen = $urandom_range(25, 200);
            else
                plen = $urandom_range(0, 24);
            lenf  = 8 + plen;
            total = 8 + plen;
            if (kind < 55)
            begin
                if ($urandom_range(0, 4) == 0)
                    cmode = CK_ZERO;
                if ($urandom_range(0, 4) == 0)
                    total = total + $urandom_range(1, 4);
            end
            else if (kind < 67)
            begin
                cmode = CK_FLIP;
            end
            else if (kind < 75)
            begin
                plen  = $urandom_range(1, 30);
                lenf  = 8 + plen;
                total = $urandom_range(8, 7 + plen);
            end
            else if (kind < 82)
            begin
                cmode = CK_RAND;
                total = $urandom_range(1, 7);
            end
            else if (kind < 89)
            begin
                lenf  = $urandom_range(0, 7);
                plen  = $urandom_range(0, 12);
                total = 8 + plen;
            end
            else
            begin
                cmode = CK_RAND;
                lenf  = $urandom_range(0, 65535);
                plen  = $urandom_range(0, 32);
                total = $urandom_range(1, 8 + plen);
            end
            queue_dgram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'(lenf), plen,
                        total, cmode, -1, 1'b0);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every byte is taken and every verdict has come back.
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
        // Allow a few more cycles to catch any stray verdict.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #16000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/udphc_pkg.sv
rtl/udp_header_check_decode.sv
verif/tb.sv
